### hdl/assert_macros.svh
// Assertion macros shared by the scancode translator RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/scasc_pkg.sv
// Package for the scancode translator: payload structs, status and op codes,
// scancode constants and the set-1 ASCII tables. No dependencies.
package scasc_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam int unsigned RESULT_QUEUE_DEPTH = 4;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned FILL_W = 9;

  // Operation field codes
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Set-1 modifier scancodes
  localparam logic [7:0] CODE_CAPS      = 8'h3A;
  localparam logic [7:0] CODE_LSHIFT    = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT    = 8'h36;
  localparam logic [7:0] CODE_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_UP = 8'hB6;
  localparam logic [7:0] TABLE_SIZE     = 8'd58;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_MODIFIER = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_FETCHED  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    logic       op;
    logic [7:0] scancode;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [CHAR_W-1:0]   character;
    logic [FILL_W-1:0]   fill_level;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [FILL_W-1:0] fill_level;
  } front_cmd_t;

  // Unshifted table, padded to 64 entries
  localparam logic [6:0] TAB_PLAIN [64] = '{
    7'h00, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Shifted table, padded to 64 entries
  localparam logic [6:0] TAB_SHIFT [64] = '{
    7'h00, 7'h3F, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Caps lock flips the case of letters only
  function automatic logic [6:0] translate(logic caps, logic shift, logic [5:0] idx);
    logic [6:0] base;
    logic       letter;
    base   = shift ? TAB_SHIFT[idx] : TAB_PLAIN[idx];
    letter = base inside {[7'h41:7'h5A], [7'h61:7'h7A]};
    return (caps && letter) ? (base ^ 7'h20) : base;
  endfunction

endpackage

### hdl/scasc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scasc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/scasc_front.sv
// Front end: accepts requests, tracks modifier flags and character FIFO
// pointers, classifies each request and drives the character store. Uses scasc_pkg.
`include "assert_macros.svh"

module scasc_front import scasc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  in_item_t                        in_data,
  input  logic                            room,
  output logic                            in_stall,
  output front_cmd_t                      cmd,
  output logic                            ram_wr_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_wr_addr,
  output logic [CHAR_W-1:0]               ram_wr_data,
  output logic                            ram_rd_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_rd_addr
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(BUFFER_DEPTH);

  logic          caps_r, caps_nxt;
  logic          shift_r, shift_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          accept;
  logic          is_caps;
  logic          is_shift;
  logic          full;
  logic          empty;
  status_t       status;

  assign in_stall = !room;
  assign accept   = in_valid && !in_stall;

  // Classify the request against current flags and fill
  assign is_caps  = in_data.scancode == CODE_CAPS;
  assign is_shift = in_data.scancode inside {CODE_LSHIFT, CODE_RSHIFT,
                                             CODE_LSHIFT_UP, CODE_RSHIFT_UP};
  assign full     = count_r == CNT_FULL;
  assign empty    = count_r == '0;

  always_comb begin
    if (in_data.op == OP_FETCH) begin
      status = empty ? ST_EMPTY : ST_FETCHED;
    end else if (is_caps || is_shift) begin
      status = ST_MODIFIER;
    end else if (full) begin
      status = ST_OVERFLOW;
    end else if (in_data.scancode < TABLE_SIZE) begin
      status = ST_STORED;
    end else begin
      status = ST_IGNORED;
    end
  end

  // Advance flags, pointers and fill on an accepted request
  always_comb begin
    caps_nxt   = caps_r;
    shift_nxt  = shift_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      case (status)
        ST_FETCHED: begin
          rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
          count_nxt  = count_r - 1'b1;
        end
        ST_STORED: begin
          wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
          count_nxt  = count_r + 1'b1;
        end
        ST_MODIFIER: begin
          caps_nxt  = caps_r ^ is_caps;
          shift_nxt = shift_r ^ is_shift;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r   <= 1'b0;
      shift_r  <= 1'b0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      caps_r   <= caps_nxt;
      shift_r  <= shift_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Drive the character store
  assign ram_wr_en   = accept && status == ST_STORED;
  assign ram_wr_addr = wr_ptr_r;
  assign ram_wr_data = translate(caps_r, shift_r, in_data.scancode[5:0]);
  assign ram_rd_en   = accept && status == ST_FETCHED;
  assign ram_rd_addr = rd_ptr_r;

  // Hand the classified request to the back end
  assign cmd.valid      = accept;
  assign cmd.status     = status;
  assign cmd.fill_level = FILL_W'(count_nxt);

  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_FULL, "character count above depth")
  `ASSERT_NEXT(a_store_grows, accept && status == ST_STORED,
               count_r == $past(count_r) + 1'b1, "store did not grow the count")
  `ASSERT_IMPL(a_one_ram_op, 1'b1, !(ram_wr_en && ram_rd_en), "write and read in one cycle")

endmodule

### hdl/scasc_back.sv
// Back end: joins the classified request with the store's read data and
// queues finished results for the output channel. Uses scasc_pkg.
`include "assert_macros.svh"

module scasc_back import scasc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  front_cmd_t        cmd,
  input  logic [CHAR_W-1:0] rd_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int unsigned QW = $clog2(RESULT_QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(RESULT_QUEUE_DEPTH + 1);

  front_cmd_t  pend_r;
  out_item_t   result;
  out_item_t   q_mem_r [RESULT_QUEUE_DEPTH];
  logic [QW-1:0] q_wr_r, q_wr_nxt;
  logic [QW-1:0] q_rd_r, q_rd_nxt;
  logic [NW-1:0] q_cnt_r, q_cnt_nxt;
  logic          push;
  logic          pop;
  logic [NW:0]   q_used;

  // Register the request while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= cmd;
    end
  end

  // Build the result; only a fetch carries a character
  assign result.status     = pend_r.status;
  assign result.character  = (pend_r.status == ST_FETCHED) ? rd_data : '0;
  assign result.fill_level = pend_r.fill_level;

  assign push = pend_r.valid;
  assign pop  = out_valid && !out_stall;

  // Advance queue pointers and occupancy
  always_comb begin
    q_wr_nxt  = push ? QW'(q_wr_r + 1'b1) : q_wr_r;
    q_rd_nxt  = pop ? QW'(q_rd_r + 1'b1) : q_rd_r;
    q_cnt_nxt = q_cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_nxt;
      q_rd_r  <= q_rd_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wr_r] <= result;
    end
  end

  assign out_valid = q_cnt_r != '0;
  assign out_data  = q_mem_r[q_rd_r];

  // Leave a slot for the request still in flight
  assign q_used = (NW + 1)'(q_cnt_r) + (NW + 1)'(pend_r.valid);
  assign room   = q_used < (NW + 1)'(RESULT_QUEUE_DEPTH);

  `ASSERT_IMPL(a_queue_bound, 1'b1, q_cnt_r <= NW'(RESULT_QUEUE_DEPTH), "result queue overrun")
  `ASSERT_NEXT(a_push_visible, push, out_valid, "pushed result not presented")
  `ASSERT_IMPL(a_char_zero, push && pend_r.status != ST_FETCHED,
               result.character == '0, "character on a non-fetch result")

endmodule

### hdl/scancode_to_ascii_fifo.sv
// Top level of the set-1 scancode to ASCII translator with character FIFO.
// Instantiates scasc_front, scasc_ram and scasc_back; uses scasc_pkg.
//
//   channel | ports                            | moves
//   --------+----------------------------------+--------------------------------
//   in      | in_valid, in_stall, in_data      | scancode or fetch request
//   out     | out_valid, out_stall, out_data   | status, character, fill level
//
// One request accepted per cycle while in_stall is low; the registered request
// and the store's registered read meet in the back end, which queues the result.
// Reset clears flags, pointers and counts; the character store is not cleared.
// in_stall rises when the four-entry result queue plus the request in flight
// leaves no free slot; out_stall only holds results in that queue.
module scancode_to_ascii_fifo import scasc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  front_cmd_t        cmd;
  logic              room;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [CHAR_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [CHAR_W-1:0] ram_rd_data;

  // Classify requests and manage the FIFO pointers
  scasc_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .room       (room),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr)
  );

  // Character store
  scasc_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Assemble and queue results
  scasc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_data  (ram_rd_data),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

### sim/scancode_to_ascii_fifo_tb.sv
// Testbench for scancode_to_ascii_fifo: set-1 scancode translation, caps and shift
// flags and the character FIFO, checked against an in-bench predictor.
// Depends on scasc_pkg and the scancode_to_ascii_fifo RTL.
module scancode_to_ascii_fifo_tb;
  import scasc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 21;

  // Set-1 key tables without and with shift; caps flips letter case afterward
  localparam bit [6:0] UNSHIFTED_KEYS [0:57] = '{
    7'h00, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20
  };
  localparam bit [6:0] SHIFTED_KEYS [0:57] = '{
    7'h00, 7'h3F, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predicted keyboard and FIFO state
  logic       caps_on     = 1'b0;
  logic       shift_on    = 1'b0;
  logic [6:0] char_ring [RING_DEPTH];
  logic [7:0] ring_head   = '0;
  int         ring_count  = 0;

  out_item_t  pending_results [$];
  int         mismatch_count  = 0;
  int         cycle_count     = 0;
  logic       sender_idle_on  = 1'b1;
  logic       receiver_idle_on = 1'b1;
  int         holdoff_ask     = 0;
  int         holdoff_left    = 0;
  logic       holdoff_used    = 1'b0;

  scancode_to_ascii_fifo #(.BUFFER_DEPTH(RING_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic is_shift_code(logic [7:0] code);
    return code inside {CODE_LSHIFT, CODE_RSHIFT, CODE_LSHIFT_UP, CODE_RSHIFT_UP};
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic out_item_t predict_keystroke(in_item_t req);
    out_item_t  res;
    logic [6:0] key;
    logic [7:0] slot;
    res.status    = ST_IGNORED;
    res.character = '0;
    if (req.op == OP_FETCH) begin
      if (ring_count != 0) begin
        res.character = char_ring[ring_head];
        ring_head     = ring_head + 8'd1;
        ring_count    = ring_count - 1;
        res.status    = ST_FETCHED;
      end else begin
        res.status = ST_EMPTY;
      end
    end else if (req.scancode == CODE_CAPS) begin
      caps_on    = !caps_on;
      res.status = ST_MODIFIER;
    end else if (is_shift_code(req.scancode)) begin
      shift_on   = !shift_on;
      res.status = ST_MODIFIER;
    end else if (ring_count >= RING_DEPTH) begin
      res.status = ST_OVERFLOW;
    end else if (req.scancode < TABLE_SIZE) begin
      key = shift_on ? SHIFTED_KEYS[req.scancode] : UNSHIFTED_KEYS[req.scancode];
      if (caps_on && (key inside {[7'h41:7'h5A], [7'h61:7'h7A]}))
        key = key ^ 7'h20;
      slot            = ring_head + ring_count[7:0];
      char_ring[slot] = key;
      ring_count      = ring_count + 1;
      res.status      = ST_STORED;
    end
    res.fill_level = ring_count[8:0];
    return res;
  endfunction

  // Offer one request, hold it until accepted, then queue its expected result
  task automatic send_request(input logic op, input logic [7:0] code);
    in_item_t req;
    req.op       = op;
    req.scancode = code;
    if (sender_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_keystroke(req));
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_fifo();
    while (ring_count != 0) send_request(OP_FETCH, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] random_storing_code();
    logic [7:0] code;
    do code = 8'($urandom_range(TABLE_SIZE - 1)); while (is_shift_code(code));
    return code;
  endfunction

  // Table corners, every flag combination, unknown codes and empty fetches
  task automatic test_directed_keys();
    send_request(OP_FETCH, 8'hFF);
    send_request(OP_SCAN, 8'h00);
    send_request(OP_SCAN, 8'h1D);
    send_request(OP_SCAN, 8'h37);
    send_request(OP_SCAN, 8'h39);
    send_request(OP_SCAN, TABLE_SIZE);
    send_request(OP_SCAN, 8'hFF);
    send_request(OP_SCAN, 8'h80);
    send_request(OP_SCAN, 8'h10);
    send_request(OP_SCAN, CODE_CAPS);
    send_request(OP_SCAN, 8'h10);
    send_request(OP_SCAN, CODE_LSHIFT);
    send_request(OP_SCAN, 8'h02);
    send_request(OP_SCAN, 8'h10);
    send_request(OP_SCAN, CODE_CAPS);
    send_request(OP_SCAN, 8'h10);
    send_request(OP_SCAN, CODE_LSHIFT_UP);
    send_request(OP_SCAN, CODE_RSHIFT);
    send_request(OP_SCAN, CODE_RSHIFT_UP);
    send_request(OP_SCAN, 8'h38);
    send_request(OP_FETCH, CODE_CAPS);
    drain_fifo();
    send_request(OP_FETCH, 8'h00);
  endtask

  // Fill to the top behind a long receiver hold-off, overflow, then drain
  task automatic test_fill_and_overflow();
    wait_for_results();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    holdoff_ask      = 200;
    while (ring_count < RING_DEPTH) send_request(OP_SCAN, random_storing_code());
    send_request(OP_SCAN, 8'h10);
    send_request(OP_SCAN, 8'h00);
    send_request(OP_SCAN, 8'hFF);
    send_request(OP_SCAN, CODE_CAPS);
    send_request(OP_SCAN, CODE_RSHIFT);
    send_request(OP_SCAN, 8'h1E);
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    send_request(OP_FETCH, 8'h55);
    send_request(OP_SCAN, 8'h1E);
    send_request(OP_SCAN, 8'h1E);
    drain_fifo();
    send_request(OP_FETCH, 8'hAA);
  endtask

  // Mostly typing with modifiers and fetches, some arbitrary codes
  task automatic test_random_typing();
    int pick;
    for (int i = 0; i < 100; i++) begin
      if (i == 50) wait_for_results();
      pick = $urandom_range(99);
      if (pick < 45)
        send_request(OP_SCAN, 8'($urandom_range(TABLE_SIZE - 1)));
      else if (pick < 55)
        case ($urandom_range(4))
          0: send_request(OP_SCAN, CODE_CAPS);
          1: send_request(OP_SCAN, CODE_LSHIFT);
          2: send_request(OP_SCAN, CODE_RSHIFT);
          3: send_request(OP_SCAN, CODE_LSHIFT_UP);
          default: send_request(OP_SCAN, CODE_RSHIFT_UP);
        endcase
      else if (pick < 65)
        send_request(OP_SCAN, 8'($urandom_range(255)));
      else
        send_request(OP_FETCH, 8'($urandom_range(255)));
    end
    drain_fifo();
  endtask

  // Receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_ask != 0 && !holdoff_used) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_ask;
      holdoff_used <= 1'b1;
    end else if (receiver_idle_on) begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d char %0d fill %0d",
               out_data.status, out_data.character, out_data.fill_level);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.character !== want.character) begin
          $error("character: expected %0d, actual %0d", want.character, out_data.character);
          mismatch_count++;
        end
        if (out_data.fill_level !== want.fill_level) begin
          $error("fill_level: expected %0d, actual %0d", want.fill_level,
                 out_data.fill_level);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("scancode_to_ascii_fifo verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_keys();
    test_fill_and_overflow();
    test_random_typing();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("scancode_to_ascii_fifo verification clean");
    else
      $display("scancode_to_ascii_fifo verification failed");
    $finish;
  end

endmodule
